// File: sv/srsp_pkg.sv
// Shared types, states and constants of the stranded region signal profile unit.
package srsp_pkg;

  // One input item as it arrives on the input channel.
  typedef struct packed {
    logic               mode;
    logic [2:0]         set_index;
    logic [30:0]        region_start;
    logic [30:0]        region_end;
    logic               region_minus;
    logic [30:0]        signal_start;
    logic [30:0]        signal_end;
    logic signed [31:0] signal_value;
    logic [11:0]        bin_index;
  } in_item_t;

  // One result item as it leaves on the result channel.
  typedef struct packed {
    logic signed [31:0] average;
    logic               has_data;
    logic [23:0]        hit_count;
  } out_item_t;

  localparam int SUM_W   = 56;
  localparam int COUNT_W = 24;
  localparam int CFG_W   = 13;
  localparam int QUO_CNT_W = 6;

  // One entry of the bin store: running sum and hit count.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [COUNT_W-1:0]      count;
  } entry_t;

  localparam logic MODE_ACC  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam int REG_BINS_IN_USE = 0;
  localparam logic [CFG_W-1:0] BINS_RESET = 13'd4096;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_SETUP,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_MEM,
    ST_RD_DATA,
    ST_DIV,
    ST_DONE
  } fsm_t;

endpackage

// File: sv/srsp_store.sv
// Bin store: one synchronous memory of sums and counts with a clearing pass after reset.
module srsp_store #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output srsp_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  srsp_pkg::entry_t     wr_data,
  output logic                 busy
);

  srsp_pkg::entry_t mem [DEPTH];
  srsp_pkg::entry_t rd_data_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              we;
  logic [ADDR_W-1:0] wa;
  srsp_pkg::entry_t  wd;

  // The clearing pass owns the write port until every entry is zero.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (32'(clr_addr_r) == DEPTH - 1) begin
        clr_busy_nxt = 1'b0;
      end
    end
    we = clr_busy_r ? 1'b1 : wr_en;
    wa = clr_busy_r ? clr_addr_r : wr_addr;
    wd = clr_busy_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

// File: sv/srsp_div.sv
// Restoring divider: unsigned sum magnitude by hit count, one quotient bit per cycle.
module srsp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [srsp_pkg::SUM_W-1:0]    dividend,
  input  logic [srsp_pkg::COUNT_W-1:0]  divisor,
  output logic                          done,
  output logic [srsp_pkg::SUM_W-1:0]    quotient
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [srsp_pkg::QUO_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [srsp_pkg::COUNT_W-1:0]        rem_r, rem_nxt;
  logic [srsp_pkg::SUM_W-1:0]          quo_r, quo_nxt;
  logic [srsp_pkg::COUNT_W-1:0]        dvs_r, dvs_nxt;
  logic [srsp_pkg::COUNT_W:0]          rem_sh;
  logic [srsp_pkg::COUNT_W+1:0]        diff;

  // One shift and trial subtract per cycle; the quotient shifts in where the dividend leaves.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, quo_r[srsp_pkg::SUM_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[srsp_pkg::COUNT_W+1]) begin
        rem_nxt = diff[srsp_pkg::COUNT_W-1:0];
        quo_nxt = {quo_r[srsp_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[srsp_pkg::COUNT_W-1:0];
        quo_nxt = {quo_r[srsp_pkg::SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (32'(cnt_r) == srsp_pkg::SUM_W - 1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/stranded_region_signal_profile_unit.sv
// Top level of the stranded region signal profile unit: sequencer, config register, output stage.
// Usage:
// An input item on in_valid/in_ready either accumulates one signal overlap into a
// region set profile (mode 0, no result) or reads one bin (mode 1, one result item
// on out_valid/out_ready with the bin average, a data flag and the hit count).
// Sums and counts live in one memory of NUM_SETS * MAX_BINS entries with a registered
// read; an accumulate item passes one setup step, then every covered bin is a read
// followed by a write, over at most the clamped profile length of bins.
// A read item reads its bin from memory and, when the bin holds data, divides the sum
// magnitude by the hit count in the restoring divider; an empty bin skips the divider,
// and a bin past the profile end or in an unused set skips the memory read and divider.
// One item is worked on at a time; in_ready is high only while the sequencer idles.
// After reset a clearing pass zeroes the memory, one entry per cycle, over all
// NUM_SETS * MAX_BINS entries (32768 at the defaults); no item is taken meanwhile,
// but register writes on the APB port are accepted at once.
// A result waits in an output register while the receiver stalls; the next item is
// still taken, and a later read holds in its last state until that register frees.
module stranded_region_signal_profile_unit #(
  parameter int MAX_BINS = 4096,
  parameter int NUM_SETS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srsp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srsp_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int DEPTH  = NUM_SETS * MAX_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LW     = $clog2(MAX_BINS + 1);

  srsp_pkg::fsm_t       state_r, state_nxt;
  srsp_pkg::in_item_t   item_r, item_nxt;
  logic [srsp_pkg::CFG_W-1:0] bins_r;
  logic [LW-1:0]        len_r;
  logic [LW-1:0]        p_r, p_nxt;
  logic [LW-1:0]        hi_r, hi_nxt;
  logic signed [31:0]   avg_r, avg_nxt;
  logic                 has_r, has_nxt;
  logic [srsp_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  srsp_pkg::out_item_t  out_data_r, out_data_nxt;

  logic                 store_busy;
  logic                 rd_en, wr_en;
  logic [ADDR_W-1:0]    addr;
  srsp_pkg::entry_t     rd_data, wr_data;
  logic                 div_start, div_done;
  logic [srsp_pkg::SUM_W-1:0] div_quo, mag;

  logic                 cfg_wr;
  logic [32:0]          rs, re, ss, se, off_c;
  logic signed [32:0]   len_c;
  logic [33:0]          end_c;
  logic                 set_ok, skip_c;
  logic [LW-1:0]        bin_c;
  logic signed [srsp_pkg::SUM_W:0] sum_c;

  // Configuration register: raw value for read-back and the clamped profile length.
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(srsp_pkg::REG_BINS_IN_USE));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= srsp_pkg::BINS_RESET;
      len_r  <= (32'(srsp_pkg::BINS_RESET) > MAX_BINS) ? LW'(MAX_BINS)
                                                       : LW'(srsp_pkg::BINS_RESET);
    end else if (cfg_wr) begin
      bins_r <= pwdata[srsp_pkg::CFG_W-1:0];
      if (pwdata[srsp_pkg::CFG_W-1:0] == '0) begin
        len_r <= LW'(1);
      end else if (32'(pwdata[srsp_pkg::CFG_W-1:0]) > MAX_BINS) begin
        len_r <= LW'(MAX_BINS);
      end else begin
        len_r <= LW'(pwdata[srsp_pkg::CFG_W-1:0]);
      end
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'(srsp_pkg::REG_BINS_IN_USE)) ? 32'(bins_r) : '0;

  // Overlap of the held item with its region, in wide unsigned and signed terms.
  always_comb begin
    rs = 33'(item_r.region_start);
    re = 33'(item_r.region_end);
    ss = 33'(item_r.signal_start);
    se = 33'(item_r.signal_end);
    if (ss > rs) begin
      off_c = ss - rs;
      len_c = (se >= re) ? $signed(re - ss) : $signed(se - ss);
    end else begin
      off_c = '0;
      len_c = (se > re) ? $signed(re - rs) : $signed(se - rs);
    end
    end_c  = {1'b0, off_c} + {len_c[32], len_c};
    set_ok = 32'(item_r.set_index) < NUM_SETS;
    skip_c = !set_ok || (len_c <= 0) || (off_c >= 33'(len_r));
  end

  // Bin and memory address for the current step.
  always_comb begin
    if (item_r.mode == srsp_pkg::MODE_READ) begin
      bin_c = LW'(item_r.bin_index);
    end else if (item_r.region_minus) begin
      bin_c = len_r - LW'(1) - p_r;
    end else begin
      bin_c = p_r;
    end
    addr = ADDR_W'(32'(item_r.set_index) * MAX_BINS + 32'(bin_c));
  end

  // Saturating update of the entry read back from the store.
  always_comb begin
    sum_c = {rd_data.sum[srsp_pkg::SUM_W-1], rd_data.sum}
          + (srsp_pkg::SUM_W+1)'(item_r.signal_value);
    wr_data.sum = sum_c[srsp_pkg::SUM_W-1:0];
    if (sum_c[srsp_pkg::SUM_W] != sum_c[srsp_pkg::SUM_W-1]) begin
      wr_data.sum = sum_c[srsp_pkg::SUM_W] ? {1'b1, {(srsp_pkg::SUM_W-1){1'b0}}}
                                           : {1'b0, {(srsp_pkg::SUM_W-1){1'b1}}};
    end
    wr_data.count = (rd_data.count == srsp_pkg::COUNT_MAX) ? rd_data.count
                                                             : rd_data.count + 1'b1;
    mag = rd_data.sum[srsp_pkg::SUM_W-1] ? (srsp_pkg::SUM_W)'(-rd_data.sum)
                                          : rd_data.sum;
  end

  // Sequencer: next state, loop counters and result fields.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    p_nxt         = p_r;
    hi_nxt        = hi_r;
    avg_nxt       = avg_r;
    has_nxt       = has_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    div_start     = 1'b0;
    case (state_r)
      srsp_pkg::ST_IDLE: begin
        in_ready = !store_busy;
        if (in_valid && !store_busy) begin
          item_nxt = in_data;
          avg_nxt  = '0;
          has_nxt  = 1'b0;
          cnt_nxt  = '0;
          state_nxt = (in_data.mode == srsp_pkg::MODE_READ) ? srsp_pkg::ST_RD_MEM
                                                            : srsp_pkg::ST_ACC_SETUP;
        end
      end
      srsp_pkg::ST_ACC_SETUP: begin
        p_nxt  = LW'(off_c);
        hi_nxt = (end_c > 34'(len_r)) ? len_r : LW'(end_c);
        state_nxt = skip_c ? srsp_pkg::ST_IDLE : srsp_pkg::ST_ACC_RD;
      end
      srsp_pkg::ST_ACC_RD: begin
        rd_en     = 1'b1;
        state_nxt = srsp_pkg::ST_ACC_WR;
      end
      srsp_pkg::ST_ACC_WR: begin
        wr_en = 1'b1;
        p_nxt = p_r + 1'b1;
        state_nxt = (p_r + 1'b1 == hi_r) ? srsp_pkg::ST_IDLE : srsp_pkg::ST_ACC_RD;
      end
      srsp_pkg::ST_RD_MEM: begin
        if (!set_ok || (32'(item_r.bin_index) >= 32'(len_r))) begin
          state_nxt = srsp_pkg::ST_DONE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = srsp_pkg::ST_RD_DATA;
        end
      end
      srsp_pkg::ST_RD_DATA: begin
        if (rd_data.count == '0) begin
          state_nxt = srsp_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          neg_nxt   = rd_data.sum[srsp_pkg::SUM_W-1];
          cnt_nxt   = rd_data.count;
          has_nxt   = 1'b1;
          state_nxt = srsp_pkg::ST_DIV;
        end
      end
      srsp_pkg::ST_DIV: begin
        if (div_done) begin
          if (neg_r) begin
            avg_nxt = (div_quo > 56'h80000000) ? 32'sh80000000 : -$signed(div_quo[31:0]);
          end else begin
            avg_nxt = (div_quo > 56'h7fffffff) ? 32'sh7fffffff : $signed(div_quo[31:0]);
          end
          state_nxt = srsp_pkg::ST_DONE;
        end
      end
      srsp_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.average   = avg_r;
          out_data_nxt.has_data  = has_r;
          out_data_nxt.hit_count = cnt_r;
          state_nxt = srsp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srsp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    p_r        <= p_nxt;
    hi_r       <= hi_nxt;
    avg_r      <= avg_nxt;
    has_r      <= has_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  srsp_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data),
    .busy    (store_busy)
  );

  srsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (rd_data.count),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

// File: sv/srsp_checker.sv
// Port-level checks of the profile unit and their binding to the top level.
module srsp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input srsp_pkg::out_item_t out_data,
  input logic                pready
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A bin without data reports zero average and zero hits.
  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_data |-> out_data.average == 0 && out_data.hit_count == 0)
    else $error("no-data result carries values");

  // A bin with data has been hit at least once.
  a_has_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.has_data |-> out_data.hit_count != 0)
    else $error("data flag set with zero hits");

  // One item at a time: ready drops right after an item is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken back to back");

  // The register port never waits.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind stranded_region_signal_profile_unit srsp_checker u_srsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

// File: tb/sv/tb_stranded_region_signal_profile_unit.sv
// Testbench for the stranded region signal profile unit: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb_stranded_region_signal_profile_unit;

  localparam int NBINS = 4096;
  localparam int NSETS = 8;
  localparam int STALL_LIMIT = 200000;
  localparam logic signed [srsp_pkg::SUM_W-1:0] SUM_TOP =
    {1'b0, {(srsp_pkg::SUM_W-1){1'b1}}};
  localparam logic signed [srsp_pkg::SUM_W-1:0] SUM_BOT =
    {1'b1, {(srsp_pkg::SUM_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  srsp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srsp_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stranded_region_signal_profile_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state: profile sums and counts for every set and bin.
  logic signed [srsp_pkg::SUM_W-1:0] prof_sum [NSETS*NBINS];
  logic [srsp_pkg::COUNT_W-1:0] prof_cnt [NSETS*NBINS];
  logic [srsp_pkg::CFG_W-1:0] bins_reg;
  srsp_pkg::out_item_t expected_averages[$];
  int send_gap_pct;
  int recv_stall_pct;
  int errors;
  int idle_cycles;

  function automatic int profile_length();
    if (bins_reg == 0) return 1;
    if (bins_reg > NBINS) return NBINS;
    return int'(bins_reg);
  endfunction

  // Apply one item to the predictor; reads queue their expected result.
  task automatic predict_item(input srsp_pkg::in_item_t it);
    longint rs, re, ss, se, offs, len, hi, p, lim, b;
    int idx;
    logic signed [srsp_pkg::SUM_W:0] s;
    logic signed [srsp_pkg::SUM_W-1:0] q;
    srsp_pkg::out_item_t r;
    lim = profile_length();
    if (it.mode == srsp_pkg::MODE_ACC) begin
      if (it.set_index >= NSETS) return;
      rs = it.region_start; re = it.region_end;
      ss = it.signal_start; se = it.signal_end;
      if (ss > rs) begin
        offs = ss - rs;
        len = (se >= re) ? re - ss : se - ss;
      end else begin
        offs = 0;
        len = (se > re) ? re - rs : se - rs;
      end
      if (len <= 0 || offs >= lim) return;
      hi = offs + len;
      if (hi > lim) hi = lim;
      for (p = offs; p < hi; p++) begin
        b = it.region_minus ? lim - 1 - p : p;
        idx = int'(it.set_index) * NBINS + int'(b);
        s = prof_sum[idx] + it.signal_value;
        if (s > SUM_TOP) s = SUM_TOP;
        if (s < SUM_BOT) s = SUM_BOT;
        prof_sum[idx] = s[srsp_pkg::SUM_W-1:0];
        if (prof_cnt[idx] != srsp_pkg::COUNT_MAX) prof_cnt[idx]++;
      end
    end else begin
      r = '0;
      if (it.set_index < NSETS && it.bin_index < lim) begin
        idx = int'(it.set_index) * NBINS + int'(it.bin_index);
        if (prof_cnt[idx] != 0) begin
          q = prof_sum[idx] / $signed({1'b0, prof_cnt[idx]});
          if (q > 64'sd2147483647) r.average = 32'h7fffffff;
          else if (q < -64'sd2147483648) r.average = 32'h80000000;
          else r.average = q[31:0];
          r.has_data = 1'b1;
          r.hit_count = prof_cnt[idx];
        end
      end
      expected_averages.insert(expected_averages.size(), r);
    end
  endtask

  // Send one item, holding it until the block takes it; valid stays up until the
  // next call or drain decides what follows.
  task automatic send_item(input srsp_pkg::in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
    @(negedge clk);
  endtask

  task automatic write_bins(input logic [srsp_pkg::CFG_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * srsp_pkg::REG_BINS_IN_USE);
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    bins_reg = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Let all results drain and the block finish any accumulate work.
  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (expected_averages.size() != 0 && n < 2000000) begin
      @(posedge clk);
      n++;
    end
    repeat (2 * NBINS + 100) @(posedge clk);
  endtask

  function automatic srsp_pkg::in_item_t acc_item(int set, longint rs, longint re, bit minus,
                                                  longint ss, longint se, int val);
    srsp_pkg::in_item_t it;
    it = '0;
    it.mode = srsp_pkg::MODE_ACC; it.set_index = 3'(set);
    it.region_start = 31'(rs); it.region_end = 31'(re); it.region_minus = minus;
    it.signal_start = 31'(ss); it.signal_end = 31'(se); it.signal_value = val;
    it.bin_index = 12'($urandom);
    return it;
  endfunction

  function automatic srsp_pkg::in_item_t read_item(int set, int bin);
    srsp_pkg::in_item_t it;
    it = '0;
    it.mode = srsp_pkg::MODE_READ; it.set_index = 3'(set); it.bin_index = 12'(bin);
    it.region_start = 31'($urandom); it.signal_value = $urandom;
    return it;
  endfunction

  // Random item: mostly reads and small overlaps, some wide and noisy ones.
  function automatic srsp_pkg::in_item_t random_item();
    srsp_pkg::in_item_t it;
    longint base;
    int lim, k;
    lim = profile_length();
    k = $urandom_range(99);
    base = $urandom_range(32'h7ff00000);
    if (k < 45) begin
      it = acc_item($urandom_range(7), base, base + $urandom_range(1, 40),
                    $urandom_range(1), base + $urandom_range(0, 30) - 10,
                    base + $urandom_range(0, 50), $urandom);
    end else if (k < 50) begin
      it = acc_item($urandom_range(7), $urandom, $urandom, $urandom_range(1),
                    $urandom, $urandom, $urandom);
    end else if (k < 52) begin
      it = acc_item($urandom_range(7), base, base + $urandom_range(1, 4096), 0,
                    base, base + 5000, $urandom);
    end else begin
      it = read_item($urandom_range(7), $urandom_range(99) < 85 ?
                     $urandom_range(lim > 48 ? 47 : lim - 1) : $urandom_range(4095));
    end
    return it;
  endfunction

  task automatic test_directed();
    send_item(acc_item(0, 100, 110, 0, 95, 200, 32'h00010000));
    send_item(acc_item(0, 100, 110, 1, 103, 106, 32'h7fffffff));
    send_item(acc_item(1, 0, 20, 0, 5, 15, 32'h80000000));
    send_item(acc_item(1, 0, 20, 0, 5, 15, -3));
    send_item(acc_item(2, 50, 60, 0, 70, 80, 7));
    send_item(acc_item(2, 50, 60, 0, 10, 50, 7));
    send_item(acc_item(3, 0, 31'h7fffffff, 1, 31'h7ffffff0, 31'h7fffffff, 9));
    send_item(acc_item(3, 31'h7fffffff, 0, 0, 0, 31'h7fffffff, 9));
    send_item(acc_item(4, 0, 5000, 0, 0, 5000, 1));
    send_item(acc_item(7, 10, 15, 1, 0, 100, -1));
    send_item(read_item(0, 0));
    send_item(read_item(0, 9));
    send_item(read_item(0, 4090));
    send_item(read_item(1, 6));
    send_item(read_item(2, 0));
    send_item(read_item(3, 4095));
    send_item(read_item(4, 4095));
    send_item(read_item(5, 3));
    send_item(read_item(7, 4095));
    send_item(read_item(7, 4093));
    drain();
  endtask

  // Short profile, minus strand and reads past the end.
  task automatic test_short_profile();
    write_bins(13'd0);
    send_item(acc_item(5, 10, 20, 1, 10, 20, 100));
    send_item(read_item(5, 0));
    send_item(read_item(5, 1));
    drain();
    write_bins(13'd8191);
    send_item(acc_item(6, 0, 3, 1, 0, 3, 5));
    send_item(read_item(6, 4095));
    drain();
    write_bins(13'd1);
    drain();
  endtask

  task automatic test_random(input int n, input int lenv);
    write_bins(13'(lenv));
    repeat (n) send_item(random_item());
    drain();
  endtask

  // Check every result against the oldest expectation.
  always @(posedge clk) begin
    srsp_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_averages.size() == 0) begin
        $error("unexpected result: average %0d", out_data.average);
        errors++;
      end else begin
        e = expected_averages.pop_front();
        if (out_data.average !== e.average) begin
          $error("average: expected %0d, got %0d", e.average, out_data.average);
          errors++;
        end
        if (out_data.has_data !== e.has_data) begin
          $error("has_data: expected %0d, got %0d", e.has_data, out_data.has_data);
          errors++;
        end
        if (out_data.hit_count !== e.hit_count) begin
          $error("hit_count: expected %0d, got %0d", e.hit_count, out_data.hit_count);
          errors++;
        end
      end
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog on cycles with no accepted item, result or register access; its limit also covers the clearing pass.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT + NSETS * NBINS) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    bins_reg = srsp_pkg::BINS_RESET;
    send_gap_pct = 25;
    recv_stall_pct = 87;
    for (int i = 0; i < NSETS * NBINS; i++) begin
      prof_sum[i] = '0;
      prof_cnt[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_short_profile();
    test_random(550, 4096);
    send_gap_pct = 87;
    recv_stall_pct = 25;
    test_random(550, 37);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random(550, 2);
    if (expected_averages.size() != 0) errors++;
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: files.f
sv/srsp_pkg.sv
sv/srsp_store.sv
sv/srsp_div.sv
sv/stranded_region_signal_profile_unit.sv
sv/srsp_checker.sv
tb/sv/tb_stranded_region_signal_profile_unit.sv
